[design/eti_pkg.sv]
// ============================================================================
// eti_pkg: shared types and helpers for the escape-time iterator
// Fixed-point word type, point and configuration records, the request and
// response records of the shared multiplier, and saturating add and subtract.
// ============================================================================
package eti_pkg;

    localparam int FX_W       = 64;
    localparam int HALF_W     = FX_W / 2;
    localparam int PROD_W     = 2 * FX_W;
    localparam int IN_W       = 32;
    localparam int IN_FRAC    = 28;
    localparam int ITER_W     = 16;
    localparam int BOUND_W    = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    typedef logic signed [FX_W-1:0] t_fx;

    localparam t_fx FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
    localparam t_fx FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERATIONS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BOUND_SQ = 8'd1;

    typedef struct packed {
        t_fx re;
        t_fx im;
    } t_point;

    typedef struct packed {
        logic [ITER_W-1:0]  max_iterations;
        logic [BOUND_W-1:0] escape_bound_sq;
    } t_cfg;

    typedef struct packed {
        logic start;
        t_fx  a;
        t_fx  b;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
        t_fx  p;
    } t_mul_rsp;

    function automatic t_fx fx_sat_add(input t_fx a, input t_fx b);
        logic [FX_W:0] s;
        s = {a[FX_W-1], a} + {b[FX_W-1], b};
        if (s[FX_W] != s[FX_W-1]) begin
            return s[FX_W] ? FX_MIN : FX_MAX;
        end
        return t_fx'(s[FX_W-1:0]);
    endfunction

    function automatic t_fx fx_sat_sub(input t_fx a, input t_fx b);
        logic [FX_W:0] s;
        s = {a[FX_W-1], a} - {b[FX_W-1], b};
        if (s[FX_W] != s[FX_W-1]) begin
            return s[FX_W] ? FX_MIN : FX_MAX;
        end
        return t_fx'(s[FX_W-1:0]);
    endfunction

endpackage

[design/eti_front.sv]
// ============================================================================
// eti_front: input stage of the escape-time iterator
// Takes one point word, converts both coordinates to the internal fixed-point
// format and hands the result to the point queue.
// ============================================================================
module eti_front import eti_pkg::*; #(
    parameter int FRAC_BITS = 28
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [IN_W-1:0] i_c_real,
    input  logic signed [IN_W-1:0] i_c_imag,
    output logic                   o_push,
    output t_point                 o_point,
    input  logic                   i_q_full
);

    localparam int UP = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
    localparam int DN = (FRAC_BITS <  IN_FRAC) ? IN_FRAC - FRAC_BITS : 0;

    // Widening is exact; narrowing rounds toward minus infinity.
    function automatic t_fx to_fx(input logic [IN_W-1:0] raw);
        t_fx ext;
        ext = {{(FX_W-IN_W){raw[IN_W-1]}}, raw};
        return (ext <<< UP) >>> DN;
    endfunction

    logic   r_valid;
    t_point r_point;
    logic   w_take;

    assign o_stall = r_valid && i_q_full;
    assign o_push  = r_valid && !i_q_full;
    assign w_take  = i_valid && !o_stall;
    assign o_point = r_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_point.re <= to_fx(i_c_real);
            r_point.im <= to_fx(i_c_imag);
        end
    end

endmodule

[design/eti_queue.sv]
// ============================================================================
// eti_queue: short point queue between front and back
// A small register FIFO so that the input side and the iteration engine can
// stall independently of each other.
// ============================================================================
module eti_queue import eti_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_point i_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_point o_data,
    output logic   o_empty
);

    t_point          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/eti_mul.sv]
// ============================================================================
// eti_mul: multi-cycle saturating fixed-point multiplier
// Multiplies two signed words by magnitude, one 32x32 partial product a cycle,
// then scales by the fraction width and saturates to the signed word range.
// ============================================================================
module eti_mul import eti_pkg::*; #(
    parameter int FRAC_BITS = 28
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_MAG  = 3'd1;
    localparam logic [2:0] P_MUL  = 3'd2;
    localparam logic [2:0] P_TAIL = 3'd3;
    localparam logic [2:0] P_FIN  = 3'd4;

    logic [2:0]        r_phase;
    logic [2:0]        n_phase;
    logic [1:0]        r_k;
    logic              r_pp_v;
    logic [1:0]        r_pp_k;
    logic [FX_W-1:0]   r_pp;
    t_fx               r_a;
    t_fx               r_b;
    logic [FX_W-1:0]   r_ua;
    logic [FX_W-1:0]   r_ub;
    logic              r_neg;
    logic [PROD_W-1:0] r_acc;
    logic              r_done;
    t_fx               r_p;

    logic [HALF_W-1:0] w_sel_a;
    logic [HALF_W-1:0] w_sel_b;
    logic [FX_W-1:0]   w_pp;
    logic [PROD_W-1:0] w_addend;
    logic [FX_W-1:0]   w_rlo;
    logic              w_ovf;
    t_fx               w_final;

    // Partial product order: low*low, low*high, high*low, high*high.
    assign w_sel_a = r_k[1] ? r_ua[FX_W-1:HALF_W] : r_ua[HALF_W-1:0];
    assign w_sel_b = r_k[0] ? r_ub[FX_W-1:HALF_W] : r_ub[HALF_W-1:0];
    assign w_pp    = w_sel_a * w_sel_b;

    always_comb begin
        case (r_pp_k)
            2'd0:    w_addend = {{FX_W{1'b0}}, r_pp};
            2'd3:    w_addend = {r_pp, {FX_W{1'b0}}};
            default: w_addend = {{HALF_W{1'b0}}, r_pp, {HALF_W{1'b0}}};
        endcase
    end

    assign w_rlo = r_acc[FRAC_BITS +: FX_W];
    assign w_ovf = (|r_acc[PROD_W-1:FRAC_BITS+FX_W]) || w_rlo[FX_W-1];

    always_comb begin
        if (w_ovf) begin
            w_final = r_neg ? FX_MIN : FX_MAX;
        end else if (r_neg) begin
            w_final = t_fx'(-w_rlo);
        end else begin
            w_final = t_fx'(w_rlo);
        end
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            P_IDLE: begin
                if (i_req.start) begin
                    n_phase = P_MAG;
                end
            end
            P_MAG: n_phase = P_MUL;
            P_MUL: begin
                if (r_k == 2'd3) begin
                    n_phase = P_TAIL;
                end
            end
            P_TAIL:  n_phase = P_FIN;
            P_FIN:   n_phase = P_IDLE;
            default: n_phase = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_k     <= '0;
            r_pp_v  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pp_v  <= (r_phase == P_MUL);
            r_done  <= (r_phase == P_FIN);
            if (r_phase == P_MAG) begin
                r_k <= '0;
            end else if (r_phase == P_MUL) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == P_IDLE && i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        if (r_phase == P_MAG) begin
            r_ua  <= r_a[FX_W-1] ? -r_a : r_a;
            r_ub  <= r_b[FX_W-1] ? -r_b : r_b;
            r_neg <= r_a[FX_W-1] ^ r_b[FX_W-1];
            r_acc <= '0;
        end else if (r_pp_v) begin
            r_acc <= r_acc + w_addend;
        end
        if (r_phase == P_MUL) begin
            r_pp   <= w_pp;
            r_pp_k <= r_k;
        end
        if (r_phase == P_FIN) begin
            r_p <= w_final;
        end
    end

    assign o_rsp.busy = (r_phase != P_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;

endmodule

[design/eti_back.sv]
// ============================================================================
// eti_back: iteration engine of the escape-time iterator
// Pops one point, runs z = z*z + c through the shared multiplier step by
// step, tests the squared magnitude and writes the result word.
// ============================================================================
module eti_back import eti_pkg::*; #(
    parameter int FRAC_BITS = 28
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_q_empty,
    input  t_point            i_q_data,
    output logic              o_pop,
    output t_mul_req          o_mul_req,
    input  t_mul_rsp          i_mul_rsp,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_escaped,
    output logic [ITER_W-1:0] o_iteration_index
);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_CROSS_GO   = 3'd1;
    localparam logic [2:0] S_CROSS_WAIT = 3'd2;
    localparam logic [2:0] S_SQR_GO     = 3'd3;
    localparam logic [2:0] S_SQR_WAIT   = 3'd4;
    localparam logic [2:0] S_SQI_GO     = 3'd5;
    localparam logic [2:0] S_SQI_WAIT   = 3'd6;
    localparam logic [2:0] S_CHECK      = 3'd7;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    t_fx               r_cr;
    t_fx               r_ci;
    t_fx               r_zr;
    t_fx               r_zi;
    t_fx               r_sqr;
    t_fx               r_sqi;
    t_fx               r_diff;
    logic [ITER_W-1:0] r_step;
    logic              r_out_valid;
    logic              r_escaped;
    logic [ITER_W-1:0] r_index;

    logic w_out_free;
    t_fx  w_mag;
    t_fx  w_bound;
    logic w_escape;
    logic w_last;
    logic w_stop;
    logic w_finish;
    logic w_zero;
    logic w_begin;

    assign w_out_free = !r_out_valid || !i_out_stall;
    // The squares of the new z serve both the escape test and the next step.
    assign w_mag      = fx_sat_add(r_sqr, r_sqi);
    assign w_bound    = t_fx'(i_cfg.escape_bound_sq) << FRAC_BITS;
    assign w_escape   = (w_mag > w_bound);
    assign w_last     = (({1'b0, r_step} + 1'b1) == {1'b0, i_cfg.max_iterations});
    assign w_stop     = w_escape || w_last;
    assign w_finish   = (r_state == S_CHECK) && w_stop && w_out_free;
    assign w_begin    = (r_state == S_IDLE) && !i_q_empty && (i_cfg.max_iterations != '0);
    assign w_zero     = (r_state == S_IDLE) && !i_q_empty && (i_cfg.max_iterations == '0)
                        && w_out_free;
    assign o_pop      = w_begin || w_zero;

    always_comb begin
        o_mul_req.start = 1'b0;
        o_mul_req.a     = r_zi;
        o_mul_req.b     = r_zi;
        unique case (r_state)
            S_CROSS_GO: begin
                o_mul_req.start = 1'b1;
                o_mul_req.a     = fx_sat_add(r_zr, r_zr);
                o_mul_req.b     = r_zi;
            end
            S_SQR_GO: begin
                o_mul_req.start = 1'b1;
                o_mul_req.a     = r_zr;
                o_mul_req.b     = r_zr;
            end
            S_SQI_GO: begin
                o_mul_req.start = 1'b1;
            end
            default: begin
                o_mul_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_begin) begin
                    n_state = S_CROSS_GO;
                end
            end
            S_CROSS_GO: n_state = S_CROSS_WAIT;
            S_CROSS_WAIT: begin
                if (i_mul_rsp.done) begin
                    n_state = S_SQR_GO;
                end
            end
            S_SQR_GO: n_state = S_SQR_WAIT;
            S_SQR_WAIT: begin
                if (i_mul_rsp.done) begin
                    n_state = S_SQI_GO;
                end
            end
            S_SQI_GO: n_state = S_SQI_WAIT;
            S_SQI_WAIT: begin
                if (i_mul_rsp.done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!w_stop) begin
                    n_state = S_CROSS_GO;
                end else if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_finish || w_zero) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_begin) begin
            r_cr   <= i_q_data.re;
            r_ci   <= i_q_data.im;
            r_zr   <= '0;
            r_zi   <= '0;
            r_sqr  <= '0;
            r_sqi  <= '0;
            r_step <= '0;
        end
        if (r_state == S_CROSS_GO) begin
            r_diff <= fx_sat_sub(r_sqr, r_sqi);
        end
        if (r_state == S_CROSS_WAIT && i_mul_rsp.done) begin
            r_zr <= fx_sat_add(r_diff, r_cr);
            r_zi <= fx_sat_add(i_mul_rsp.p, r_ci);
        end
        if (r_state == S_SQR_WAIT && i_mul_rsp.done) begin
            r_sqr <= i_mul_rsp.p;
        end
        if (r_state == S_SQI_WAIT && i_mul_rsp.done) begin
            r_sqi <= i_mul_rsp.p;
        end
        if (r_state == S_CHECK && !w_stop) begin
            r_step <= r_step + 1'b1;
        end
        if (w_finish) begin
            r_escaped <= w_escape;
            r_index   <= w_escape ? r_step : '0;
        end else if (w_zero) begin
            r_escaped <= 1'b0;
            r_index   <= '0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_escaped         = r_escaped;
    assign o_iteration_index = r_index;

endmodule

[design/escape_time_iterator_top.sv]
// ============================================================================
// escape_time_iterator_top: Mandelbrot escape-time iterator
// Iterates z = z*z + c per point and reports the step at which it escapes.
// ============================================================================
// Usage. The input channel carries one point word (c_real, c_imag, signed
// Q3.28) under i_in_valid / o_in_stall. The result channel carries one word
// (escaped, iteration_index) under o_out_valid / i_out_stall. A word moves at
// a rising edge where valid is high and stall is low. The configuration port
// (i_cfg_valid / o_cfg_ready, index and data) is always ready. It should only
// be written while no point is in flight.
// Flow. A point passes through the front register and the two-entry queue
// before the engine picks it up. The engine shares one 64x64 multiplier,
// built from 32x32 partial products, for the three products of a step
// (cross term and two squares). A point takes the escaping step plus one
// steps, or max_iterations steps if it stays bounded. With max_iterations of
// zero the result word is posted straight from the queue without iterating.
// Points are handled one at a time by the engine, while up to three more
// wait in the front register and the queue.
// Reset clears all control state and loads max_iterations = 256 and
// escape_bound_sq = 4. A stalled result word holds; the engine keeps
// iterating the next point and waits only when it has a new result to post.
// ============================================================================
module escape_time_iterator_top import eti_pkg::*; #(
    parameter int FRAC_BITS = 28
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [IN_W-1:0] i_c_real,
    input  logic signed [IN_W-1:0] i_c_imag,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_escaped,
    output logic [ITER_W-1:0]     o_iteration_index,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [ITER_W-1:0]  MAX_ITER_RESET = 16'd256;
    localparam logic [BOUND_W-1:0] BOUND_RESET    = 7'd4;

    logic [ITER_W-1:0]  r_max_iterations;
    logic [BOUND_W-1:0] r_escape_bound_sq;
    t_cfg               w_cfg;

    logic     w_push;
    t_point   w_front_point;
    logic     w_q_full;
    logic     w_q_empty;
    t_point   w_q_data;
    logic     w_pop;
    t_mul_req w_mul_req;
    t_mul_rsp w_mul_rsp;

    // Configuration registers. Writes to an unknown index are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iterations  <= MAX_ITER_RESET;
            r_escape_bound_sq <= BOUND_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_MAX_ITERATIONS:  r_max_iterations  <= i_cfg_data[ITER_W-1:0];
                REG_ESCAPE_BOUND_SQ: r_escape_bound_sq <= i_cfg_data[BOUND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.max_iterations  = r_max_iterations;
    assign w_cfg.escape_bound_sq = r_escape_bound_sq;

    // Front: takes a point word and converts it to the internal format.
    eti_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_c_real (i_c_real),
        .i_c_imag (i_c_imag),
        .o_push   (w_push),
        .o_point  (w_front_point),
        .i_q_full (w_q_full)
    );

    // Queue: decouples the input side from the iteration engine.
    eti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_point),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    // Back: the step sequencer and the result register.
    eti_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (w_cfg),
        .i_q_empty         (w_q_empty),
        .i_q_data          (w_q_data),
        .o_pop             (w_pop),
        .o_mul_req         (w_mul_req),
        .i_mul_rsp         (w_mul_rsp),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_escaped         (o_escaped),
        .o_iteration_index (o_iteration_index)
    );

    // The one multiplier that every product of a step goes through.
    eti_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    // The engine must not launch a product while the multiplier is working.
    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_req.start |-> !w_mul_rsp.busy)
        else $error("multiplier started while busy");

    // A finished product always closes a product that was in progress.
    a_mul_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> $past(w_mul_rsp.busy))
        else $error("multiplier done without a product in progress");

    // The engine only takes points that the queue holds.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("point queue popped while empty");

    // A product that the engine launches is picked up by the multiplier, which then shows busy.
    a_wait_covered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_req.start |=> w_mul_rsp.busy)
        else $error("multiplier did not pick up a launched product");

endmodule
